// ----- rtl/crb_pkg.sv -----
// Shared types, constants and helpers of the checked register bank.
package crb_pkg;

  // Register file geometry
  localparam int REG_W    = 16;
  localparam int NUM_REGS = 16;
  localparam int REG_AW   = 4;

  // Special registers
  localparam logic [REG_AW-1:0] IDX_PC = 4'd11;
  localparam logic [REG_AW-1:0] IDX_SP = 4'd12;
  localparam logic [REG_AW-1:0] IDX_SR = 4'd15;

  // Request codes
  typedef enum logic [2:0] {
    FN_WR_REG  = 3'd0,
    FN_RD_REG  = 3'd1,
    FN_WR_FLAG = 3'd2,
    FN_RD_FLAG = 3'd3,
    FN_RESTART = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_REG   = 3'd1,
    ST_SP_CODE  = 3'd2,
    ST_PC_STACK = 3'd3,
    ST_NO_FLAG  = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CODE_START = 3'd0,
    CFG_CODE_END   = 3'd1,
    CFG_STACK_CHK  = 3'd2,
    CFG_PC_CHK     = 3'd3,
    CFG_STACK_DESC = 3'd4
  } cfg_idx_t;

  // Configuration as seen by the control logic
  typedef struct packed {
    logic [REG_W-1:0] code_start;
    logic [REG_W-1:0] code_end;
    logic             stack_check_enable;
    logic             pc_check_enable;
    logic             stack_descending;
  } cfg_t;

  // v lies between a and b, bounds in either order, ends included
  function automatic logic between_either(input logic [REG_W-1:0] v,
                                          input logic [REG_W-1:0] a,
                                          input logic [REG_W-1:0] b);
    between_either = ((v >= a) && (v <= b)) || ((v <= a) && (v >= b));
  endfunction

endpackage

// ----- rtl/crb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module crb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/crb_ctrl.sv -----
// Request decode, bound checks, flag vector and result stage of the register bank.
module crb_ctrl #(
  parameter int NUM_FLAGS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  crb_pkg::cfg_t                     cfg,
  input  logic                              req,
  input  logic [2:0]                        func,
  input  logic [4:0]                        reg_index,
  input  logic [4:0]                        flag_index,
  input  logic [crb_pkg::REG_W-1:0]         write_value,
  input  logic                              flag_value,
  output logic                              ram_we,
  output logic [crb_pkg::REG_AW-1:0]        ram_waddr,
  output logic [crb_pkg::REG_W-1:0]         ram_wdata,
  output logic [crb_pkg::REG_AW-1:0]        ram_raddr,
  input  logic [crb_pkg::REG_W-1:0]         ram_rdata,
  output logic                              res_strobe,
  output logic [crb_pkg::REG_W-1:0]         res_read_value,
  output logic                              res_flag_out,
  output logic [2:0]                        res_status
);
  import crb_pkg::*;

  // Architectural state beside the RAM
  logic [NUM_REGS-1:0]  valid_r, valid_nxt;
  logic [NUM_FLAGS-1:0] flags_r, flags_nxt;
  logic [REG_W-1:0]     stack_low_r, stack_low_nxt;
  logic [REG_W-1:0]     stack_high_r, stack_high_nxt;

  // Result stage
  logic        strobe_r;
  status_t     status_r, status_nxt;
  logic        flag_out_r, flag_out_nxt;
  logic        rd_sel_r, rd_sel_nxt;
  logic        rd_live_r;

  logic [REG_AW-1:0] idx;
  logic              reg_ok;
  logic              flag_ok;
  logic              gap_wins;
  logic [REG_W-1:0]  restart_sp;

  assign idx     = reg_index[REG_AW-1:0];
  assign reg_ok  = (reg_index < 5'(NUM_REGS));
  assign flag_ok = (flag_index < 5'(NUM_FLAGS));

  // Restart stack placement: larger free gap picks the side
  assign gap_wins = (~cfg.code_end) < cfg.code_start;
  always_comb begin
    if (cfg.stack_descending) begin
      restart_sp = gap_wins ? (cfg.code_start - 16'd1) : 16'hFFFF;
    end else begin
      restart_sp = gap_wins ? 16'd0 : (cfg.code_end + 16'd1);
    end
  end

  // Decode one request
  always_comb begin
    valid_nxt      = valid_r;
    flags_nxt      = flags_r;
    stack_low_nxt  = stack_low_r;
    stack_high_nxt = stack_high_r;
    ram_we         = 1'b0;
    ram_waddr      = idx;
    ram_wdata      = write_value;
    ram_raddr      = idx;
    status_nxt     = ST_OK;
    flag_out_nxt   = 1'b0;
    rd_sel_nxt     = 1'b0;
    if (req) begin
      unique case (func)
        FN_WR_REG: begin
          if (!reg_ok) begin
            status_nxt = ST_NO_REG;
          end else if (idx == IDX_SP) begin
            if (cfg.stack_check_enable &&
                between_either(write_value, cfg.code_start, cfg.code_end)) begin
              status_nxt = ST_SP_CODE;
            end else begin
              ram_we         = 1'b1;
              stack_high_nxt = write_value;
            end
          end else if (idx == IDX_PC) begin
            if (cfg.pc_check_enable &&
                between_either(write_value, stack_low_r, stack_high_r)) begin
              status_nxt = ST_PC_STACK;
            end else begin
              ram_we = 1'b1;
            end
          end else begin
            ram_we = 1'b1;
            if (idx == IDX_SR) begin
              flags_nxt = write_value[NUM_FLAGS-1:0];
            end
          end
          if (ram_we) begin
            valid_nxt[idx] = 1'b1;
          end
        end
        FN_RD_REG: begin
          if (!reg_ok) begin
            status_nxt = ST_NO_REG;
          end else begin
            rd_sel_nxt = 1'b1;
          end
        end
        FN_WR_FLAG: begin
          if (!flag_ok) begin
            status_nxt = ST_NO_FLAG;
          end else begin
            for (int i = 0; i < NUM_FLAGS; i++) begin
              if (flag_index == 5'(i)) begin
                flags_nxt[i] = flag_value;
              end
            end
            // SR is rebuilt from the flags, upper bits clear
            ram_we            = 1'b1;
            ram_waddr         = IDX_SR;
            ram_wdata         = REG_W'(flags_nxt);
            valid_nxt[IDX_SR] = 1'b1;
          end
        end
        FN_RD_FLAG: begin
          if (!flag_ok) begin
            status_nxt = ST_NO_FLAG;
          end else begin
            for (int i = 0; i < NUM_FLAGS; i++) begin
              if (flag_index == 5'(i)) begin
                flag_out_nxt = flags_r[i];
              end
            end
          end
        end
        FN_RESTART: begin
          // Invalid entries read as zero; only SP is written
          valid_nxt         = '0;
          valid_nxt[IDX_SP] = 1'b1;
          ram_we            = 1'b1;
          ram_waddr         = IDX_SP;
          ram_wdata         = restart_sp;
          stack_low_nxt     = restart_sp;
          stack_high_nxt    = restart_sp;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      flags_r      <= '0;
      stack_low_r  <= '0;
      stack_high_r <= '0;
      strobe_r     <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      flags_r      <= flags_nxt;
      stack_low_r  <= stack_low_nxt;
      stack_high_r <= stack_high_nxt;
      strobe_r     <= req;
    end
    status_r   <= status_nxt;
    flag_out_r <= flag_out_nxt;
    rd_sel_r   <= rd_sel_nxt;
    rd_live_r  <= valid_r[idx];
  end

  // RAM data arrives with the result cycle
  assign res_strobe     = strobe_r;
  assign res_read_value = (rd_sel_r && rd_live_r) ? ram_rdata : '0;
  assign res_flag_out   = flag_out_r;
  assign res_status     = status_r;

endmodule

// ----- rtl/checked_register_bank.sv -----
// Top level of the checked register bank: configuration registers, RAM and control.
//
// Channel   Ports                                   Handshake
// request   start, busy, in_*                       taken when start && !busy
// result    out_strobe, out_*                       one cycle, no backpressure
// config    cfg_we, cfg_index, cfg_wdata            taken when cfg_we
//
// Every request yields its result in the cycle after it is taken; a new
// request may be taken every cycle, so busy stays low. The result waits on the
// registered read of the register-file RAM. Reset is synchronous and clears
// the valid bits, flags and stack bounds and resets the configuration; entries not valid
// read as zero, so no clearing pass is run. The receiver cannot stall.
module checked_register_bank #(
  parameter int NUM_FLAGS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_func,
  input  logic [4:0]                 in_reg_index,
  input  logic [4:0]                 in_flag_index,
  input  logic [crb_pkg::REG_W-1:0]  in_write_value,
  input  logic                       in_flag_value,
  output logic                       out_strobe,
  output logic [crb_pkg::REG_W-1:0]  out_read_value,
  output logic                       out_flag_out,
  output logic [2:0]                 out_status,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [crb_pkg::REG_W-1:0]  cfg_wdata
);
  import crb_pkg::*;

  cfg_t              cfg_r;
  logic              req;
  logic              ram_we;
  logic [REG_AW-1:0] ram_waddr;
  logic [REG_W-1:0]  ram_wdata;
  logic [REG_AW-1:0] ram_raddr;
  logic [REG_W-1:0]  ram_rdata;

  assign busy = 1'b0;
  assign req  = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.code_start         <= '0;
      cfg_r.code_end           <= '0;
      cfg_r.stack_check_enable <= 1'b1;
      cfg_r.pc_check_enable    <= 1'b1;
      cfg_r.stack_descending   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_START: cfg_r.code_start         <= cfg_wdata;
        CFG_CODE_END:   cfg_r.code_end           <= cfg_wdata;
        CFG_STACK_CHK:  cfg_r.stack_check_enable <= cfg_wdata[0];
        CFG_PC_CHK:     cfg_r.pc_check_enable    <= cfg_wdata[0];
        CFG_STACK_DESC: cfg_r.stack_descending   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Register file storage
  crb_ram #(
    .WIDTH (REG_W),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode, checks and result stage
  crb_ctrl #(
    .NUM_FLAGS (NUM_FLAGS)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .req            (req),
    .func           (in_func),
    .reg_index      (in_reg_index),
    .flag_index     (in_flag_index),
    .write_value    (in_write_value),
    .flag_value     (in_flag_value),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .res_strobe     (out_strobe),
    .res_read_value (out_read_value),
    .res_flag_out   (out_flag_out),
    .res_status     (out_status)
  );

endmodule

// ----- verif/tb_checked_register_bank.sv -----
// Self-checking testbench for the checked register bank: random and directed requests.
`timescale 1ns / 1ps

module tb_checked_register_bank;
  import crb_pkg::*;

  localparam int NUM_FLAGS   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 75;

  typedef struct {
    logic [2:0]       func;
    logic [4:0]       reg_index;
    logic [4:0]       flag_index;
    logic [REG_W-1:0] write_value;
    logic             flag_value;
  } bank_req_t;

  typedef struct {
    logic [REG_W-1:0] read_value;
    logic             flag_out;
    status_t          status;
  } bank_rsp_t;

  // DUT connections, inputs driven from time zero
  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             start          = 1'b0;
  logic [2:0]       in_func        = '0;
  logic [4:0]       in_reg_index   = '0;
  logic [4:0]       in_flag_index  = '0;
  logic [REG_W-1:0] in_write_value = '0;
  logic             in_flag_value  = 1'b0;
  logic             cfg_we         = 1'b0;
  logic [2:0]       cfg_index      = '0;
  logic [REG_W-1:0] cfg_wdata      = '0;
  logic             busy;
  logic             out_strobe;
  logic [REG_W-1:0] out_read_value;
  logic             out_flag_out;
  logic [2:0]       out_status;

  // Shadow of the bank and its configuration
  logic [REG_W-1:0]     bank_regs [NUM_REGS];
  logic [REG_W-1:0]     stk_lo;
  logic [REG_W-1:0]     stk_hi;
  logic [NUM_FLAGS-1:0] flag_vec;
  cfg_t                 cfg_shadow;

  bank_req_t req_q [$];
  bank_rsp_t rsp_q [$];
  bank_req_t cur_req;
  bank_rsp_t want;
  logic      taken;
  int        burst_left = 0;
  int        gap_left   = 0;
  int        err_cnt    = 0;
  int        cycle_cnt  = 0;
  logic [REG_W-1:0] sp_hint = '0;

  checked_register_bank #(.NUM_FLAGS(NUM_FLAGS)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_reg_index   (in_reg_index),
    .in_flag_index  (in_flag_index),
    .in_write_value (in_write_value),
    .in_flag_value  (in_flag_value),
    .out_strobe     (out_strobe),
    .out_read_value (out_read_value),
    .out_flag_out   (out_flag_out),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Inclusive range test, bounds in either order
  function automatic bit in_span(input logic [REG_W-1:0] v, input logic [REG_W-1:0] a,
                                 input logic [REG_W-1:0] b);
    return ((v >= a) && (v <= b)) || ((v <= a) && (v >= b));
  endfunction

  // SP placed by restart: stack direction and the larger free gap
  function automatic logic [REG_W-1:0] restart_sp();
    logic gap_wins;
    logic [REG_W-1:0] sp;
    gap_wins = (16'hFFFF - cfg_shadow.code_end) < cfg_shadow.code_start;
    if (cfg_shadow.stack_descending)
      sp = gap_wins ? cfg_shadow.code_start - 16'd1 : 16'hFFFF;
    else
      sp = gap_wins ? 16'd0 : cfg_shadow.code_end + 16'd1;
    return sp;
  endfunction

  // Applies one request to the shadow bank and returns its expected result
  function automatic bank_rsp_t predict_access(input bank_req_t rq);
    bank_rsp_t res;
    logic [3:0] ri;
    logic [REG_W-1:0] sp;
    res.read_value = '0;
    res.flag_out   = 1'b0;
    res.status     = ST_OK;
    ri = rq.reg_index[3:0];
    case (rq.func)
      FN_WR_REG: begin
        if (rq.reg_index >= NUM_REGS) begin
          res.status = ST_NO_REG;
        end else if (ri == IDX_SP) begin
          if (cfg_shadow.stack_check_enable &&
              in_span(rq.write_value, cfg_shadow.code_start, cfg_shadow.code_end)) begin
            res.status = ST_SP_CODE;
          end else begin
            bank_regs[ri] = rq.write_value;
            stk_hi = rq.write_value;
          end
        end else if (ri == IDX_PC) begin
          if (cfg_shadow.pc_check_enable && in_span(rq.write_value, stk_lo, stk_hi))
            res.status = ST_PC_STACK;
          else
            bank_regs[ri] = rq.write_value;
        end else begin
          bank_regs[ri] = rq.write_value;
          if (ri == IDX_SR) flag_vec = rq.write_value[NUM_FLAGS-1:0];
        end
      end
      FN_RD_REG: begin
        if (rq.reg_index >= NUM_REGS) res.status = ST_NO_REG;
        else res.read_value = bank_regs[ri];
      end
      FN_WR_FLAG: begin
        if (rq.flag_index >= NUM_FLAGS) begin
          res.status = ST_NO_FLAG;
        end else begin
          flag_vec[rq.flag_index] = rq.flag_value;
          // SR rebuilt from the flags, upper bits cleared
          bank_regs[IDX_SR] = '0;
          bank_regs[IDX_SR][NUM_FLAGS-1:0] = flag_vec;
        end
      end
      FN_RD_FLAG: begin
        if (rq.flag_index >= NUM_FLAGS) res.status = ST_NO_FLAG;
        else res.flag_out = flag_vec[rq.flag_index];
      end
      FN_RESTART: begin
        // flags survive a restart even though SR is cleared
        foreach (bank_regs[i]) bank_regs[i] = '0;
        sp = restart_sp();
        bank_regs[IDX_SP] = sp;
        stk_lo = sp;
        stk_hi = sp;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Request driver: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) rsp_q.push_back(predict_access(cur_req));
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          start          <= 1'b1;
          in_func        <= cur_req.func;
          in_reg_index   <= cur_req.reg_index;
          in_flag_index  <= cur_req.flag_index;
          in_write_value <= cur_req.write_value;
          in_flag_value  <= cur_req.flag_value;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare against the oldest pending expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (rsp_q.size() == 0) begin
        $display("%0t ERROR: unexpected result read=%h flag=%b status=%0d", $time,
                 out_read_value, out_flag_out, out_status);
        err_cnt++;
      end else begin
        want = rsp_q.pop_front();
        if (out_read_value !== want.read_value) begin
          $display("%0t ERROR: read_value exp %h got %h", $time, want.read_value,
                   out_read_value);
          err_cnt++;
        end
        if (out_flag_out !== want.flag_out) begin
          $display("%0t ERROR: flag_out exp %b got %b", $time, want.flag_out, out_flag_out);
          err_cnt++;
        end
        if (out_status !== want.status) begin
          $display("%0t ERROR: status exp %0d got %0d", $time, want.status, out_status);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_req(input logic [2:0] f, input logic [4:0] ri, input logic [4:0] fi,
                          input logic [REG_W-1:0] wv, input logic fv);
    bank_req_t rq;
    rq.func        = f;
    rq.reg_index   = ri;
    rq.flag_index  = fi;
    rq.write_value = wv;
    rq.flag_value  = fv;
    req_q.push_back(rq);
  endtask

  // Values clustered on the code and stack bounds, plus extremes
  function automatic logic [REG_W-1:0] pick_value();
    logic [REG_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 16'(cfg_shadow.code_start + $urandom_range(0, 4) - 2);
      1: v = 16'(cfg_shadow.code_end + $urandom_range(0, 4) - 2);
      2: v = 16'(sp_hint + $urandom_range(0, 4) - 2);
      3: v = 16'(restart_sp() + $urandom_range(0, 4) - 2);
      4: begin
        case ($urandom_range(0, 3))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          2: v = 16'h0001;
          default: v = 16'hFFFE;
        endcase
      end
      default: v = 16'($urandom_range(0, 16'hFFFF));
    endcase
    return v;
  endfunction

  // One random request, mostly well formed
  task automatic push_random_req();
    bank_req_t rq;
    int sel;
    int rsel;
    rq.func        = 3'($urandom_range(0, 7));
    rq.reg_index   = 5'($urandom_range(0, 31));
    rq.flag_index  = 5'($urandom_range(0, 31));
    rq.write_value = 16'($urandom_range(0, 16'hFFFF));
    rq.flag_value  = 1'($urandom_range(0, 1));
    sel  = $urandom_range(0, 99);
    rsel = $urandom_range(0, 99);
    if (sel < 30) begin
      rq.func = FN_WR_REG;
      rq.write_value = pick_value();
      if (rsel < 35) rq.reg_index = 5'(IDX_SP);
      else if (rsel < 55) rq.reg_index = 5'(IDX_PC);
      else if (rsel < 65) rq.reg_index = 5'(IDX_SR);
      else if (rsel < 92) rq.reg_index = 5'($urandom_range(0, NUM_REGS - 1));
      if (rq.reg_index[3:0] == IDX_SP && rq.reg_index < NUM_REGS) sp_hint = rq.write_value;
    end else if (sel < 55) begin
      rq.func = FN_RD_REG;
      if (rsel < 25) rq.reg_index = 5'(IDX_SP);
      else if (rsel < 40) rq.reg_index = 5'(IDX_PC);
      else if (rsel < 55) rq.reg_index = 5'(IDX_SR);
      else if (rsel < 92) rq.reg_index = 5'($urandom_range(0, NUM_REGS - 1));
    end else if (sel < 85) begin
      rq.func = (sel < 70) ? FN_WR_FLAG : FN_RD_FLAG;
      if (rsel < 85) rq.flag_index = 5'($urandom_range(0, NUM_FLAGS - 1));
    end else if (sel < 93) begin
      rq.func = FN_RESTART;
    end else if (sel < 97) begin
      rq.func = 3'($urandom_range(5, 7));
    end
    req_q.push_back(rq);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CODE_START: cfg_shadow.code_start         = val;
      CFG_CODE_END:   cfg_shadow.code_end           = val;
      CFG_STACK_CHK:  cfg_shadow.stack_check_enable = val[0];
      CFG_PC_CHK:     cfg_shadow.pc_check_enable    = val[0];
      CFG_STACK_DESC: cfg_shadow.stack_descending   = val[0];
      default: ;
    endcase
  endtask

  // One-bit registers get random upper bits, which the block must ignore
  task automatic load_config(input logic [REG_W-1:0] cs, input logic [REG_W-1:0] ce,
                             input logic sc, input logic pc, input logic desc);
    write_cfg(CFG_CODE_START, cs);
    write_cfg(CFG_CODE_END, ce);
    write_cfg(CFG_STACK_CHK, {15'($urandom_range(0, 32767)), sc});
    write_cfg(CFG_PC_CHK, {15'($urandom_range(0, 32767)), pc});
    write_cfg(CFG_STACK_DESC, {15'($urandom_range(0, 32767)), desc});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Block until every request is taken and answered, then let it settle
  task automatic wait_drained();
    do @(negedge clk);
    while (req_q.size() != 0 || start || rsp_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random_phase(input int n);
    @(negedge clk);
    sp_hint = restart_sp();
    push_req(FN_RESTART, 5'd0, 5'd0, 16'h0000, 1'b0);
    repeat (n - 1) push_random_req();
    wait_drained();
  endtask

  function automatic logic [REG_W-1:0] rand_bound();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Main sequence
  initial begin
    foreach (bank_regs[i]) bank_regs[i] = '0;
    stk_lo   = '0;
    stk_hi   = '0;
    flag_vec = '0;
    cfg_shadow.code_start         = '0;
    cfg_shadow.code_end           = '0;
    cfg_shadow.stack_check_enable = 1'b1;
    cfg_shadow.pc_check_enable    = 1'b1;
    cfg_shadow.stack_descending   = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset configuration (code and stack both at 0)
    @(negedge clk);
    push_req(FN_RD_REG,  5'd0,  5'd0,  16'h0000, 1'b0);
    push_req(FN_WR_REG,  5'd0,  5'd0,  16'hFFFF, 1'b1);
    push_req(FN_RD_REG,  5'd0,  5'd31, 16'h0000, 1'b0);
    push_req(FN_WR_REG,  5'd31, 5'd0,  16'h1234, 1'b0);  // no such register
    push_req(FN_RD_REG,  5'd16, 5'd0,  16'h0000, 1'b0);
    push_req(FN_WR_REG,  5'(IDX_SP), 5'd0, 16'h0000, 1'b0);  // SP into code
    push_req(FN_WR_REG,  5'(IDX_PC), 5'd0, 16'h0000, 1'b0);  // PC into stack
    push_req(FN_WR_REG,  5'(IDX_SP), 5'd0, 16'h8000, 1'b0);
    push_req(FN_WR_REG,  5'(IDX_PC), 5'd0, 16'h4000, 1'b0);  // inside 0..8000
    push_req(FN_WR_REG,  5'(IDX_PC), 5'd0, 16'hFFFF, 1'b0);
    push_req(FN_WR_FLAG, 5'd0,  5'd0,  16'h0000, 1'b1);
    push_req(FN_WR_FLAG, 5'd0,  5'(NUM_FLAGS - 1), 16'h0000, 1'b1);
    push_req(FN_WR_FLAG, 5'd0,  5'(NUM_FLAGS), 16'h0000, 1'b1);  // no such flag
    push_req(FN_RD_FLAG, 5'd0,  5'd31, 16'h0000, 1'b0);
    push_req(FN_RD_REG,  5'(IDX_SR), 5'd0, 16'h0000, 1'b0);
    push_req(FN_WR_REG,  5'(IDX_SR), 5'd0, 16'hFF5A, 1'b0);  // reloads flags
    push_req(FN_RD_FLAG, 5'd0,  5'd1,  16'h0000, 1'b0);
    push_req(FN_WR_FLAG, 5'd0,  5'd2,  16'h0000, 1'b1);  // SR upper bits cleared
    push_req(FN_RD_REG,  5'(IDX_SR), 5'd0, 16'h0000, 1'b0);
    push_req(FN_RESTART, 5'd0,  5'd0,  16'h0000, 1'b0);
    push_req(FN_RD_REG,  5'(IDX_SP), 5'd0, 16'h0000, 1'b0);
    push_req(FN_RD_FLAG, 5'd0,  5'd1,  16'h0000, 1'b0);  // flags kept over restart
    push_req(3'd5, 5'd31, 5'd31, 16'hFFFF, 1'b1);  // unused codes
    push_req(3'd6, 5'd15, 5'd7,  16'hAAAA, 1'b0);
    push_req(3'd7, 5'd0,  5'd0,  16'h5555, 1'b1);
    wait_drained();

    // Fixed settings, extremes included
    load_config(16'h1000, 16'h3FFF, 1'b1, 1'b1, 1'b1);
    run_random_phase(PHASE_ITEMS);
    load_config(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);  // reversed, whole space
    run_random_phase(PHASE_ITEMS);
    load_config(16'hF000, 16'hFFF0, 1'b1, 1'b1, 1'b0);  // code gap wins, ascending
    run_random_phase(PHASE_ITEMS);
    load_config(16'hF000, 16'hFFF0, 1'b1, 1'b1, 1'b1);  // code gap wins, descending
    run_random_phase(PHASE_ITEMS);
    load_config(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);  // SP wraps to 0, checks off
    run_random_phase(PHASE_ITEMS);
    load_config(16'h0010, 16'h0008, 1'b0, 1'b1, 1'b1);
    run_random_phase(PHASE_ITEMS);

    // Random settings
    repeat (6) begin
      load_config(rand_bound(), rand_bound(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_random_phase(PHASE_ITEMS);
    end

    repeat (8) @(posedge clk);
    err_cnt += rsp_q.size();
    if (err_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
